FILE: rtl/pgc_pkg.sv
// ----------------------------------------------------------------------------
// pgc_pkg
// Shared types and constants for the position group centroid block.
// ----------------------------------------------------------------------------
package pgc_pkg;

  localparam int MAX_POSITIONS = 4096;

  localparam int POS_W   = 12;
  localparam int SUM_W   = 24;
  localparam int COUNT_W = 13;
  localparam int THR_W   = 13;
  localparam int STEP_W  = 5;

  localparam int COUNT_MAX = (1 << COUNT_W) - 1;
  localparam int COUNT_CAP = (MAX_POSITIONS > COUNT_MAX) ? COUNT_MAX : MAX_POSITIONS;

  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(10);
  localparam logic [STEP_W-1:0] DIV_LAST_STEP   = STEP_W'(SUM_W - 1);

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last_item;
  } pgc_in_t;

  typedef struct packed {
    logic [POS_W-1:0] center;
    logic             last_center;
  } pgc_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic begin_group;
    logic accumulate;
    logic clear_group;
    logic start_div;
    logic load_out;
    logic out_last;
  } pgc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic group_open;
    logic joins;
    logic can_add;
    logic last_item;
    logic div_busy;
    logic div_done;
    logic out_free;
  } pgc_status_t;

endpackage

FILE: rtl/pgc_ctrl.sv
// ----------------------------------------------------------------------------
// pgc_ctrl
// Sequencer that decides per item whether to join, close or start a group,
// and orders the divisions and result transfers.
// ----------------------------------------------------------------------------
module pgc_ctrl
  import pgc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  pgc_status_t status,
  output pgc_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE       = 7'b0000001,
    S_DECIDE     = 7'b0000010,
    S_DIV_CLOSE  = 7'b0000100,
    S_EMIT_CLOSE = 7'b0001000,
    S_START_LAST = 7'b0010000,
    S_DIV_LAST   = 7'b0100000,
    S_EMIT_LAST  = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!status.group_open) begin
          cmd.begin_group = 1'b1;
          state_next      = status.last_item ? S_START_LAST : S_IDLE;
        end else if (status.joins) begin
          cmd.accumulate = status.can_add;
          state_next     = status.last_item ? S_START_LAST : S_IDLE;
        end else begin
          cmd.start_div = 1'b1;
          state_next    = S_DIV_CLOSE;
        end
      end
      S_DIV_CLOSE: begin
        if (status.div_done) begin
          state_next = S_EMIT_CLOSE;
        end
      end
      S_EMIT_CLOSE: begin
        if (status.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.begin_group = 1'b1;
          state_next      = status.last_item ? S_START_LAST : S_IDLE;
        end
      end
      S_START_LAST: begin
        cmd.start_div = 1'b1;
        state_next    = S_DIV_LAST;
      end
      S_DIV_LAST: begin
        if (status.div_done) begin
          state_next = S_EMIT_LAST;
        end
      end
      S_EMIT_LAST: begin
        if (status.out_free) begin
          cmd.load_out    = 1'b1;
          cmd.out_last    = 1'b1;
          cmd.clear_group = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A division is only ever started with the divider at rest.
  a_start_idle_div: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |-> !status.div_busy)
    else $error("division started while divider busy");

  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free)
    else $error("result loaded into occupied output register");

endmodule

FILE: rtl/pgc_dp.sv
// ----------------------------------------------------------------------------
// pgc_dp
// Group accumulator, bit-serial divider for the mean, threshold register and
// output register.
// ----------------------------------------------------------------------------
module pgc_dp
  import pgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  pgc_in_t          item,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  input  pgc_cmd_t         cmd,
  output pgc_status_t      status,
  output logic             result_valid,
  input  logic             result_stall,
  output pgc_out_t         result
);

  logic [THR_W-1:0]   threshold;
  logic [POS_W-1:0]   pos_q;
  logic               last_q;
  logic               group_open;
  logic [POS_W-1:0]   group_start;
  logic [SUM_W-1:0]   group_sum;
  logic [COUNT_W-1:0] group_count;

  logic [SUM_W-1:0]   div_num;
  logic [COUNT_W-1:0] div_rem;
  logic [COUNT_W-1:0] div_den;
  logic [STEP_W-1:0]  div_step;
  logic               div_busy;
  logic               div_done;

  logic [POS_W-1:0]   distance;
  logic [SUM_W:0]     sum_ext;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   trial_diff;
  logic               trial_ge;
  logic [COUNT_W-1:0] rem_next;

  assign distance = (pos_q >= group_start) ? (pos_q - group_start) : (group_start - pos_q);
  assign sum_ext  = {1'b0, group_sum} + {{(SUM_W + 1 - POS_W){1'b0}}, pos_q};

  assign trial      = {div_rem, div_num[SUM_W-1]};
  assign trial_diff = trial - {1'b0, div_den};
  assign trial_ge   = (trial >= {1'b0, div_den});
  assign rem_next   = trial_ge ? trial_diff[COUNT_W-1:0] : trial[COUNT_W-1:0];

  assign status.group_open = group_open;
  assign status.joins      = ({1'b0, distance} < threshold);
  assign status.can_add    = (group_count < COUNT_W'(COUNT_CAP)) && !sum_ext[SUM_W];
  assign status.last_item  = last_q;
  assign status.div_busy   = div_busy;
  assign status.div_done   = div_done;
  assign status.out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      pos_q  <= item.position;
      last_q <= item.last_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_open  <= 1'b0;
      group_start <= '0;
      group_sum   <= '0;
      group_count <= '0;
    end else if (cmd.clear_group) begin
      group_open  <= 1'b0;
      group_start <= '0;
      group_sum   <= '0;
      group_count <= '0;
    end else if (cmd.begin_group) begin
      group_open  <= 1'b1;
      group_start <= pos_q;
      group_sum   <= {{(SUM_W - POS_W){1'b0}}, pos_q};
      group_count <= COUNT_W'(1);
    end else if (cmd.accumulate) begin
      group_sum   <= sum_ext[SUM_W-1:0];
      group_count <= group_count + COUNT_W'(1);
    end
  end

  // Restoring division, one quotient bit per cycle; the quotient shifts
  // into the dividend register from the bottom.
  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_step <= '0;
    end else if (cmd.start_div) begin
      div_busy <= 1'b1;
      div_done <= 1'b0;
      div_step <= '0;
    end else if (div_busy) begin
      div_step <= div_step + STEP_W'(1);
      if (div_step == DIV_LAST_STEP) begin
        div_busy <= 1'b0;
        div_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      div_num <= group_sum;
      div_rem <= '0;
      div_den <= group_count;
    end else if (div_busy) begin
      div_num <= {div_num[SUM_W-2:0], trial_ge};
      div_rem <= rem_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      result.center      <= div_num[POS_W-1:0];
      result.last_center <= cmd.out_last;
    end
  end

  // An open group always holds between one and the capped number of positions.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    group_open |-> (group_count != '0) && (group_count <= COUNT_W'(COUNT_CAP)))
    else $error("group count out of range");

  // A started division keeps the divider busy in the following cycle.
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.start_div |=> div_busy && !div_done)
    else $error("divider did not start");

  // Completion is only flagged at the end of a running division.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    $rose(div_done) |-> $past(div_busy) && (div_step == '0 || !div_busy))
    else $error("divider completed without running");

endmodule

FILE: rtl/position_group_centroid_top.sv
// ----------------------------------------------------------------------------
// position_group_centroid_top
// Groups a stream of edge positions and emits each group's truncated mean.
// ----------------------------------------------------------------------------
// Sequence: an item that closes no group is taken by a transfer and a
//   decision; a mean that closes a group adds the divider steps, a state to
//   see completion and an output load, and the list's final mean adds a
//   state that starts its division; the load waits for a free output register.
// Throughput: one item at a time; the serial divider (one quotient bit per
//   cycle over a 24-bit sum) sets the cost of every closed group.
// Reset: synchronous, active high; clears the group state, the divider
//   control and the output valid, and loads the threshold with 10.
// ----------------------------------------------------------------------------
module position_group_centroid_top
  import pgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // Input channel: one edge position per transfer.
  input  logic             item_valid,
  output logic             item_stall,
  input  pgc_in_t          item,
  // Output channel: one group mean per transfer.
  output logic             result_valid,
  input  logic             result_stall,
  output pgc_out_t         result,
  // Threshold register write.
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata
);

  // The controller and the datapath talk only through these two bundles.
  pgc_cmd_t    cmd;
  pgc_status_t status;

  // The controller takes one item at a time, runs the divider when a group
  // closes or the list ends, and waits for the output register to be free
  // before loading a result. The output register lets a new item be taken
  // while the previous result still waits for its transfer.
  pgc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the threshold, the open group's start, sum and count,
  // the bit-serial divider and the output register.
  pgc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

FILE: sim/group_mean_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_mean_checker
// Watches both channels of the position group centroid block, predicts the
// group means that every accepted position causes and compares each accepted
// result against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module group_mean_checker
  import pgc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  pgc_in_t          item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  pgc_out_t         result,
  input  logic             cfg_we,
  input  logic [THR_W-1:0] cfg_wdata,
  output int               mismatches,
  output int               means_pending
);

  localparam int REPORT_LIMIT = 10;

  logic [THR_W-1:0]   join_limit;
  logic               grp_open;
  logic [POS_W-1:0]   grp_start;
  logic [SUM_W-1:0]   grp_sum;
  logic [COUNT_W-1:0] grp_count;
  pgc_out_t           expected_means[$];
  int                 mismatch_total = 0;

  function automatic logic [POS_W-1:0] group_average();
    if (grp_count == '0) return '0;
    return POS_W'(grp_sum / grp_count);
  endfunction

  function automatic void queue_mean(logic last);
    pgc_out_t m;
    m.center      = group_average();
    m.last_center = last;
    expected_means = {expected_means, m};
  endfunction

  function automatic void open_group(logic [POS_W-1:0] pos);
    grp_open  = 1'b1;
    grp_start = pos;
    grp_sum   = SUM_W'(pos);
    grp_count = COUNT_W'(1);
  endfunction

  function automatic void predict_group_means(pgc_in_t it);
    logic [POS_W-1:0] distance;
    logic [SUM_W:0]   widened;
    if (!grp_open) begin
      open_group(it.position);
    end else begin
      distance = (it.position >= grp_start) ? it.position - grp_start
                                            : grp_start - it.position;
      if ({1'b0, distance} < join_limit) begin
        // A full group, or a sum that would carry out, drops the position.
        widened = {1'b0, grp_sum} + (SUM_W + 1)'(it.position);
        if (grp_count < COUNT_W'(COUNT_CAP) && !widened[SUM_W]) begin
          grp_sum   = widened[SUM_W-1:0];
          grp_count = grp_count + 1'b1;
        end
      end else begin
        queue_mean(1'b0);
        open_group(it.position);
      end
    end
    if (it.last_item) begin
      queue_mean(1'b1);
      grp_open  = 1'b0;
      grp_start = '0;
      grp_sum   = '0;
      grp_count = '0;
    end
  endfunction

  always @(posedge clk) begin
    pgc_out_t want;
    if (rst) begin
      join_limit = THRESHOLD_RESET;
      grp_open   = 1'b0;
      grp_start  = '0;
      grp_sum    = '0;
      grp_count  = '0;
      expected_means.delete();
    end else begin
      if (cfg_we) join_limit = cfg_wdata;
      // Results are checked before the item of the same edge is predicted, so
      // an early result can never meet an expectation it did not cause.
      if (result_valid && !result_stall) begin
        if (expected_means.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= REPORT_LIMIT)
            $display("ERROR: unexpected group mean center=%0d last=%0b",
                     result.center, result.last_center);
        end else begin
          want = expected_means.pop_front();
          if (result.center !== want.center || result.last_center !== want.last_center) begin
            mismatch_total++;
            if (mismatch_total <= REPORT_LIMIT)
              $display("ERROR: group mean center=%0d last=%0b, expected center=%0d last=%0b",
                       result.center, result.last_center, want.center, want.last_center);
          end
        end
      end
      if (item_valid && !item_stall) predict_group_means(item);
    end
    mismatches    <= mismatch_total;
    means_pending <= expected_means.size();
  end

endmodule

FILE: sim/position_group_centroid_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// position_group_centroid_top_test
// Drives lists of edge positions into the position group centroid block under
// several join thresholds, with random gaps and stalls on both channels, and
// leaves the checking of every group mean to group_mean_checker.
// ----------------------------------------------------------------------------
module position_group_centroid_top_test
  import pgc_pkg::*;
();

  // The slowest legal item costs a sender gap, two divider passes and two
  // receiver stalls, and the long receiver hold comes on top. Anything near
  // this limit means the block has hung.
  localparam int STALL_LIMIT     = 2000;
  // Pause after the last expected mean, covering an item that closes no group.
  localparam int SETTLE_CYCLES   = 64;
  localparam int LONG_HOLD       = 300;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int NUM_PHASES      = 7;

  logic             clk          = 1'b0;
  logic             rst          = 1'b1;
  logic             item_valid   = 1'b0;
  logic             item_stall;
  pgc_in_t          item         = '0;
  logic             result_valid;
  logic             result_stall = 1'b0;
  pgc_out_t         result;
  logic             cfg_we       = 1'b0;
  logic [THR_W-1:0] cfg_wdata    = '0;

  int mismatches;
  int means_pending;
  int idle_cycles   = 0;
  int threshold_now = THRESHOLD_RESET;

  // When set, the matching side neither idles nor stalls for a whole phase.
  bit sender_steady   = 1'b0;
  bit receiver_steady = 1'b0;
  // Asks the receiver for one long hold-off at its next result.
  bit hold_request    = 1'b0;

  always #2 clk = ~clk;

  position_group_centroid_top dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  group_mean_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .item          (item),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .means_pending (means_pending)
  );

  // Offers one position and returns at the edge where its transfer happens.
  // The valid is only lowered when a gap is drawn, so back-to-back items keep
  // it high and simply change the payload at the accepting edge.
  task automatic send_position(input logic [POS_W-1:0] pos, input logic last);
    int gap;
    gap = sender_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {pos, last};
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // Sends one complete list. Most positions scatter round a base column so
  // that groups actually form; now and then the base jumps to close a group,
  // and a few positions land anywhere in the row.
  task automatic send_list(input int len);
    int base;
    int pos;
    int spread;
    int roll;
    spread = (threshold_now > 64) ? 64 : threshold_now + 2;
    base   = $urandom_range(0, 4095);
    for (int i = 0; i < len; i++) begin
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        pos = $urandom_range(0, 4095);
      end else begin
        if (roll <= 2) base = $urandom_range(0, 4095);
        pos = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (pos < 0) pos = 0;
        if (pos > 4095) pos = 4095;
      end
      send_position(pos[POS_W-1:0], i == len - 1);
    end
  endtask

  // Lets the block drain: every expected mean delivered, then a pause for an
  // item that is still being taken in without causing a result.
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (means_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The threshold is only changed while the block is idle.
  task automatic set_threshold(input int value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value[THR_W-1:0];
    @(posedge clk);
    cfg_we        <= 1'b0;
    threshold_now  = value;
  endtask

  // Receiver: before each result it draws a short hold-off, or the long one
  // when asked for it, and then waits for the transfer.
  initial begin
    int hold;
    forever begin
      if (hold_request) begin
        hold         = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        hold = receiver_steady ? 0 : $urandom_range(0, 4);
      end
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid || result_stall) @(posedge clk);
    end
  end

  // Watchdog: any transfer or register write counts as progress.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    int len;
    int limits[NUM_PHASES];

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under the reset threshold of 10. The first list has a
    // join at distance nine, a close at exactly the threshold, a jump between
    // the row's two ends and a last item that starts a fresh group, which
    // yields two means on one item.
    send_position(12'd100, 1'b0);
    send_position(12'd109, 1'b0);
    send_position(12'd91, 1'b0);
    send_position(12'd110, 1'b0);
    send_position(12'd4095, 1'b0);
    send_position(12'd4090, 1'b0);
    send_position(12'd0, 1'b1);
    // A list of a single position, and a list whose last item joins.
    send_position(12'd4095, 1'b1);
    send_position(12'd0, 1'b0);
    send_position(12'd5, 1'b1);
    // With a zero threshold even equal positions stay apart.
    set_threshold(0);
    send_position(12'd7, 1'b0);
    send_position(12'd7, 1'b0);
    send_position(12'd7, 1'b1);
    // A threshold above the row width gathers the whole list in one group.
    set_threshold(4096);
    send_position(12'd0, 1'b0);
    send_position(12'd4095, 1'b0);
    send_position(12'd2048, 1'b1);

    // Random part: several thresholds, each phase with its own idling mood.
    limits = '{1, 0, 4096, 4095, 24, 10, 0};
    limits[NUM_PHASES-1] = $urandom_range(2, 300);
    foreach (limits[p]) begin
      set_threshold(limits[p]);
      sender_steady   = ($urandom_range(0, 3) == 0);
      receiver_steady = ($urandom_range(0, 3) == 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
        send_list(len);
        sent += len;
      end
    end

    // Back-pressure: every position is its own group, the sender never
    // pauses and the receiver holds off for a long stretch, so the block
    // fills up and has to stall its input.
    set_threshold(0);
    sender_steady   = 1'b1;
    receiver_steady = 1'b0;
    hold_request    = 1'b1;
    send_list(40);

    settle();
    if (means_pending != 0)
      $display("ERROR: %0d group means never arrived", means_pending);
    if (mismatches == 0 && means_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: position_group_centroid_top.f
rtl/pgc_pkg.sv
rtl/pgc_ctrl.sv
rtl/pgc_dp.sv
rtl/position_group_centroid_top.sv
sim/group_mean_checker.sv
sim/position_group_centroid_top_test.sv
